@@ hw/rtl/bpa_pkg.sv @@
// Package for the buddy page allocator: sequencer states, request codes and fixed widths.
// No dependencies; used by buddy_page_allocator, bpa_checker and the testbench.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int CNT_W  = 15;   // page_count width
  localparam int IDX_W  = 14;   // page_index and block_index width
  localparam int FREE_W = 15;   // free_count width
  localparam int ORD_W  = 5;    // rounded order of a 15-bit count
  localparam int TOT_W  = 48;   // internal free page counter
  localparam logic [FREE_W-1:0] FREE_SAT = '1;

  // Request codes carried on the action field
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_FIND,
    S_A_UNL,
    S_A_SPLIT,
    S_A_FIN,
    S_F_META,
    S_F_BUD,
    S_F_MRG,
    S_F_MRG2,
    S_PUSH,
    S_PUSH2,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/buddy_page_allocator.sv @@
// Buddy page allocator top level: sequencer over a page metadata memory
// and a list link memory. Depends on bpa_pkg.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | action, page_count, page_index
//  out     | output    | out_valid / out_ready| ok, block_index, free_count
//
//  One request at a time. Allocate runs find and unlink, then split and push per
//  split level; free reads the metadata, then runs a buddy check and merge steps per
//  merge level, then a push. The link memory has a single write port.
//  After reset a clearing pass writes NUM_PAGES metadata entries, one a cycle,
//  with in_ready low. A request is taken while the previous result still waits;
//  the sequencer holds its result until the output register frees.
module buddy_page_allocator #(
  parameter int NUM_ORDERS = 15,
  parameter int NUM_PAGES  = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [bpa_pkg::CNT_W-1:0]  page_count,
  input  logic [bpa_pkg::IDX_W-1:0]  page_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ok,
  output logic [bpa_pkg::IDX_W-1:0]  block_index,
  output logic [bpa_pkg::FREE_W-1:0] free_count
);
  import bpa_pkg::*;

  localparam int IW = $clog2(NUM_PAGES);
  localparam int KW = $clog2(NUM_ORDERS);

  typedef struct packed {
    logic          free;
    logic [KW-1:0] order;
  } meta_t;

  typedef struct packed {
    logic          nv;
    logic [IW-1:0] n;
    logic          pv;
    logic [IW-1:0] p;
  } link_t;

  // Memories
  meta_t meta_mem [NUM_PAGES];
  link_t link_mem [NUM_PAGES];
  meta_t meta_q;
  link_t link_q;

  logic          meta_re, meta_we;
  logic [IW-1:0] meta_raddr, meta_waddr;
  meta_t         meta_wdata;
  logic          lnk_re, lnk_we_n, lnk_we_p;
  logic [IW-1:0] lnk_raddr, lnk_waddr;
  logic          lnk_wnv, lnk_wpv;
  logic [IW-1:0] lnk_wn, lnk_wp;

  // Control and working registers
  state_t state, state_next;
  logic [IW-1:0]    clr_cnt;
  logic             is_free;
  logic [CNT_W-1:0] cnt_r;
  logic [ORD_W-1:0] ord_r;
  logic [KW-1:0]    k;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    pidx;
  logic [IW-1:0]    bud_r;
  logic [IW-1:0]    hsave;
  logic             head_vld [NUM_ORDERS];
  logic [IW-1:0]    head_idx [NUM_ORDERS];
  logic [TOT_W-1:0] total;
  logic             res_ok;
  logic [IW-1:0]    res_blk;

  // Combinational helpers
  logic [ORD_W-1:0] ord_raw;
  logic             ord_ok;
  logic             found;
  logic [KW-1:0]    found_k;
  logic [TOT_W-1:0] pow_k;
  logic [TOT_W-1:0] total_sub;
  logic [31:0]      bud32, up32;
  logic [KW-1:0]    kk;
  logic             in_range;
  logic             accept;
  logic             out_load;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign in_range = 32'(page_index) < NUM_PAGES;
  assign pow_k    = TOT_W'(1) << k;
  assign total_sub = (total >= pow_k) ? total - pow_k : '0;
  assign kk       = k - KW'(1);
  assign bud32    = 32'(idx) ^ (32'd1 << k);
  assign up32     = 32'(idx) ^ (32'd1 << kk);

  // Round the count up to an order and find the first non-empty list
  always_comb begin
    ord_raw = ORD_W'(CNT_W);
    for (int j = CNT_W; j >= 0; j--) begin
      if ((32'd1 << j) >= 32'(cnt_r)) ord_raw = ORD_W'(j);
    end
    ord_ok  = (cnt_r != '0) && (32'(ord_raw) < NUM_ORDERS);
    found   = 1'b0;
    found_k = '0;
    for (int j = 0; j < NUM_ORDERS; j++) begin
      if (!found && j >= 32'(ord_raw) && head_vld[j]) begin
        found   = 1'b1;
        found_k = KW'(j);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr_cnt == IW'(NUM_PAGES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_ALLOC) state_next = S_A_FIND;
          else if (in_range) state_next = S_F_META;
          else state_next = S_DONE;
        end
      end
      S_A_FIND:  state_next = (ord_ok && found) ? S_A_UNL : S_DONE;
      S_A_UNL:   state_next = S_A_SPLIT;
      S_A_SPLIT: begin
        if (32'(k) > 32'(ord_r)) state_next = (up32 < NUM_PAGES) ? S_PUSH : S_A_SPLIT;
        else state_next = S_A_FIN;
      end
      S_A_FIN:   state_next = S_DONE;
      S_F_META: begin
        if (meta_q.free || 32'(meta_q.order) >= NUM_ORDERS) state_next = S_DONE;
        else state_next = S_F_BUD;
      end
      S_F_BUD: begin
        if (32'(k) < NUM_ORDERS - 1 && bud32 < NUM_PAGES) state_next = S_F_MRG;
        else state_next = S_PUSH;
      end
      S_F_MRG: begin
        if (!meta_q.free || meta_q.order != k) state_next = S_PUSH;
        else state_next = S_F_MRG2;
      end
      S_F_MRG2:  state_next = S_F_BUD;
      S_PUSH: begin
        if (head_vld[k]) state_next = S_PUSH2;
        else state_next = is_free ? S_DONE : S_A_SPLIT;
      end
      S_PUSH2:   state_next = is_free ? S_DONE : S_A_SPLIT;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    meta_re    = 1'b0;
    meta_raddr = IW'(page_index);
    meta_we    = 1'b0;
    meta_waddr = idx;
    meta_wdata = '0;
    lnk_re     = 1'b0;
    lnk_raddr  = bud_r;
    lnk_we_n   = 1'b0;
    lnk_we_p   = 1'b0;
    lnk_waddr  = pidx;
    lnk_wnv    = 1'b0;
    lnk_wn     = '0;
    lnk_wpv    = 1'b0;
    lnk_wp     = '0;
    case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt;
      end
      S_IDLE: begin
        meta_re = accept && (action == ACT_FREE) && in_range;
      end
      S_A_FIND: begin
        lnk_re    = ord_ok && found;
        lnk_raddr = head_idx[found_k];
      end
      S_A_UNL: begin
        lnk_we_p  = link_q.nv;
        lnk_waddr = link_q.n;
      end
      S_A_FIN: begin
        meta_we    = 1'b1;
        meta_waddr = idx;
        meta_wdata = '{free: 1'b0, order: KW'(ord_r)};
      end
      S_F_BUD: begin
        if (32'(k) < NUM_ORDERS - 1 && bud32 < NUM_PAGES) begin
          meta_re    = 1'b1;
          meta_raddr = IW'(bud32);
          lnk_re     = 1'b1;
          lnk_raddr  = IW'(bud32);
        end
      end
      S_F_MRG: begin
        if (meta_q.free && meta_q.order == k) begin
          meta_we    = 1'b1;
          meta_waddr = bud_r;
          meta_wdata = '{free: 1'b0, order: k};
          lnk_we_n   = link_q.pv;
          lnk_waddr  = link_q.p;
          lnk_wnv    = link_q.nv;
          lnk_wn     = link_q.n;
        end
      end
      S_F_MRG2: begin
        meta_we    = 1'b1;
        meta_waddr = (bud_r < idx) ? bud_r : idx;
        meta_wdata = '{free: 1'b0, order: k + KW'(1)};
        lnk_we_p   = link_q.nv;
        lnk_waddr  = link_q.n;
        lnk_wpv    = link_q.pv;
        lnk_wp     = link_q.p;
      end
      S_PUSH: begin
        meta_we    = 1'b1;
        meta_waddr = pidx;
        meta_wdata = '{free: 1'b1, order: k};
        lnk_we_n   = 1'b1;
        lnk_we_p   = 1'b1;
        lnk_waddr  = pidx;
        lnk_wnv    = head_vld[k];
        lnk_wn     = head_idx[k];
      end
      S_PUSH2: begin
        lnk_we_p   = 1'b1;
        lnk_waddr  = hsave;
        lnk_wpv    = 1'b1;
        lnk_wp     = pidx;
      end
      default: begin
      end
    endcase
  end

  // Metadata memory
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_q <= meta_mem[meta_raddr];
  end

  // Link memory with per-field writes
  always_ff @(posedge clk) begin
    if (lnk_we_n) begin
      link_mem[lnk_waddr].nv <= lnk_wnv;
      link_mem[lnk_waddr].n  <= lnk_wn;
    end
    if (lnk_we_p) begin
      link_mem[lnk_waddr].pv <= lnk_wpv;
      link_mem[lnk_waddr].p  <= lnk_wp;
    end
    if (lnk_re) link_q <= link_mem[lnk_raddr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      total   <= '0;
      for (int j = 0; j < NUM_ORDERS; j++) head_vld[j] <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + IW'(1);
        S_IDLE: begin
          if (accept) begin
            is_free <= (action == ACT_FREE);
            cnt_r   <= page_count;
            idx     <= IW'(page_index);
            res_ok  <= 1'b0;
            res_blk <= '0;
          end
        end
        S_A_FIND: begin
          ord_r <= ord_raw;
          k     <= found_k;
          idx   <= head_idx[found_k];
        end
        S_A_UNL: begin
          head_vld[k] <= link_q.nv;
          head_idx[k] <= link_q.n;
          total       <= total_sub;
        end
        S_A_SPLIT: begin
          if (32'(k) > 32'(ord_r)) begin
            k    <= kk;
            pidx <= IW'(up32);
          end
        end
        S_A_FIN: begin
          res_ok  <= 1'b1;
          res_blk <= idx;
        end
        S_F_META: k <= meta_q.order;
        S_F_BUD: begin
          bud_r <= IW'(bud32);
          pidx  <= idx;
        end
        S_F_MRG: begin
          if (meta_q.free && meta_q.order == k) begin
            if (!link_q.pv) begin
              head_vld[k] <= link_q.nv;
              head_idx[k] <= link_q.n;
            end
            total <= total_sub;
          end
        end
        S_F_MRG2: begin
          if (bud_r < idx) idx <= bud_r;
          k <= k + KW'(1);
        end
        S_PUSH: begin
          hsave       <= head_idx[k];
          head_vld[k] <= 1'b1;
          head_idx[k] <= pidx;
          total       <= total + pow_k;
          if (is_free) res_ok <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok          <= res_ok;
      block_index <= IDX_W'(res_blk);
      free_count  <= (total > TOT_W'(FREE_SAT)) ? FREE_SAT : FREE_W'(total);
    end
  end

endmodule

@@ hw/rtl/bpa_checker.sv @@
// Port-level checker for buddy_page_allocator, with its bind statement.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       ok,
  input logic [bpa_pkg::IDX_W-1:0]  block_index,
  input logic [bpa_pkg::FREE_W-1:0] free_count
);
  import bpa_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(block_index)
      && $stable(free_count))
    else $error("stalled result changed");

  // Report block zero on a failed request
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> block_index == '0)
    else $error("failed request with nonzero block");

  // Hold off requests during the clearing pass
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during clearing pass");

  // Take one request at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
  .block_index(block_index), .free_count(free_count)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for buddy_page_allocator: a scoreboard class predicts
// every allocate/free request; a task drives the request channel and a receiver block drives out_ready.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam int NPAGES = 16384;
  localparam int NORDERS = 15;
  localparam int unsigned NIL = 32'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_STALL = 400;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] block;
    logic [FREE_W-1:0] free;
  } alloc_result_t;

  // Predicts allocator results and holds them until the block returns them.
  class alloc_scoreboard;
    int unsigned order_of[NPAGES];
    bit          is_head[NPAGES];
    int unsigned nxt[NPAGES];
    int unsigned prv[NPAGES];
    int unsigned head[NORDERS];
    int unsigned blocks[NORDERS];
    longint unsigned total;
    alloc_result_t expected_results[$];
    int mismatches, checked, alloc_ok, alloc_fail, frees_done, frees_ignored, top_order;

    function new();
      for (int i = 0; i < NPAGES; i++) begin
        order_of[i] = 0; is_head[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
      for (int k = 0; k < NORDERS; k++) begin
        head[k] = NIL; blocks[k] = 0;
      end
      total = 0;
    endfunction

    function void push_free_block(int unsigned idx, int unsigned k);
      int unsigned h;
      h = head[k];
      prv[idx] = NIL;
      nxt[idx] = h;
      if (h < NPAGES) prv[h] = idx;
      head[k] = idx;
      is_head[idx] = 1;
      order_of[idx] = k;
      blocks[k]++;
      total += 64'd1 << k;
      if (k > top_order) top_order = k;
    endfunction

    function void unlink_free_block(int unsigned idx, int unsigned k);
      int unsigned p, n;
      p = prv[idx];
      n = nxt[idx];
      if (p < NPAGES) nxt[p] = n;
      else head[k] = n;
      if (n < NPAGES) prv[n] = p;
      is_head[idx] = 0;
      if (blocks[k] > 0) blocks[k]--;
      if (total >= (64'd1 << k)) total -= 64'd1 << k;
      else total = 0;
    endfunction

    function bit predict_alloc(int unsigned cnt, output int unsigned where);
      int unsigned ord, size, k, idx;
      where = 0;
      if (cnt == 0) return 0;
      ord = 0; size = 1;
      while (size < cnt) begin
        size <<= 1; ord++;
      end
      if (ord >= NORDERS) return 0;
      for (k = ord; k < NORDERS; k++)
        if (head[k] < NPAGES) break;
      if (k >= NORDERS) return 0;
      idx = head[k];
      unlink_free_block(idx, k);
      while (k > ord) begin
        k--;
        if ((idx ^ (1 << k)) < NPAGES) push_free_block(idx ^ (1 << k), k);
      end
      order_of[idx] = ord;
      where = idx;
      return 1;
    endfunction

    function bit predict_free(int unsigned idx);
      int unsigned k, b;
      if (idx >= NPAGES || is_head[idx]) return 0;
      k = order_of[idx];
      if (k >= NORDERS) return 0;
      while (k < NORDERS - 1) begin
        b = idx ^ (1 << k);
        if (b >= NPAGES || !is_head[b] || order_of[b] != k) break;
        unlink_free_block(b, k);
        if (b < idx) idx = b;
        k++;
        order_of[idx] = k;
      end
      push_free_block(idx, k);
      return 1;
    endfunction

    // Note an accepted request; hand back the predicted result to the driver.
    function alloc_result_t note(bit act, int unsigned cnt, int unsigned idx);
      alloc_result_t r;
      int unsigned where;
      where = 0;
      if (act == ACT_ALLOC) begin
        r.ok = predict_alloc(cnt, where);
        if (r.ok) alloc_ok++; else alloc_fail++;
      end else begin
        r.ok = predict_free(idx);
        if (r.ok) frees_done++; else frees_ignored++;
      end
      r.block = where[IDX_W-1:0];
      r.free = (total > 64'h7FFF) ? FREE_SAT : total[FREE_W-1:0];
      expected_results.push_back(r);
      return r;
    endfunction

    function void check(alloc_result_t got);
      alloc_result_t exp_r;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request pending: %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (exp_r !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected ok=%0d block=%0d free=%0d, got ok=%0d block=%0d free=%0d",
                   checked, exp_r.ok, exp_r.block, exp_r.free, got.ok, got.block, got.free);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, action, out_valid, out_ready, ok;
  logic [CNT_W-1:0] page_count;
  logic [IDX_W-1:0] page_index, block_index;
  logic [FREE_W-1:0] free_count;

  alloc_scoreboard sb = new();
  int unsigned live_blocks[$];
  int cycles = 0;
  bit no_gaps = 0;
  int unsigned last_freed = 0;

  buddy_page_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .page_count(page_count), .page_index(page_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .block_index(block_index), .free_count(free_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check('{ok: ok, block: block_index, free: free_count});
  end

  // Receiver: random stalls, gap-free stretches, one long hold-off.
  initial begin
    int gap, taken;
    taken = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken == 600) gap = LONG_STALL;
      else if (no_gaps) gap = 0;
      else gap = $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send(bit act, int unsigned cnt, int unsigned idx);
    int gap;
    alloc_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    page_count <= cnt[CNT_W-1:0];
    page_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (!in_ready);
    r = sb.note(act, cnt & 32'h7FFF, idx & 32'h3FFF);
    if (act == ACT_ALLOC && r.ok) live_blocks.push_back(32'(r.block));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned perm[512];
    int unsigned tmp, j, pick, r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_ALLOC;
    page_count <= '0;
    page_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pool, extremes, double free, merge, split, free inside a block.
    send(ACT_ALLOC, 0, 0);
    send(ACT_ALLOC, 1, 0);
    send(ACT_FREE, 0, 16383);
    send(ACT_FREE, 0, 16383);
    send(ACT_FREE, 32767, 16382);
    send(ACT_ALLOC, 32767, 16383);
    send(ACT_ALLOC, 16384, 0);
    send(ACT_ALLOC, 16385, 0);
    send(ACT_ALLOC, 3, 0);
    send(ACT_ALLOC, 2, 0);
    send(ACT_FREE, 0, 16382);
    send(ACT_ALLOC, 1, 0);
    send(ACT_FREE, 0, 16383);
    send(ACT_FREE, 0, 16382);
    send(ACT_FREE, 0, 16383);
    send(ACT_ALLOC, 1, 0);
    send(ACT_ALLOC, 1, 0);
    send(ACT_ALLOC, 1, 0);
    live_blocks.delete();

    // Seed the pool: free pages 0..511 one at a time in shuffled order.
    for (int i = 0; i < 512; i++) perm[i] = i;
    for (int i = 511; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int i = 0; i < 512; i++) begin
      if (i % 128 == 64) no_gaps = ~no_gaps;
      send(ACT_FREE, 0, perm[i]);
    end

    // Hold the sender until every pending result has come back.
    wait_drained();

    // Random mix: mostly allocate/free of live blocks, some broken requests.
    for (int i = 0; i < 1220; i++) begin
      if (i % 100 == 50) no_gaps = ~no_gaps;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        tmp = $urandom_range(0, 9);
        if (tmp < 7) send(ACT_ALLOC, $urandom_range(1, 8), $urandom);
        else if (tmp < 9) send(ACT_ALLOC, $urandom_range(1, 128), $urandom);
        else send(ACT_ALLOC, $urandom, $urandom);
      end else if (r < 85 && live_blocks.size() > 0) begin
        pick = $urandom_range(0, live_blocks.size() - 1);
        last_freed = live_blocks[pick];
        live_blocks.delete(pick);
        send(ACT_FREE, $urandom, last_freed);
      end else if (r < 90) begin
        send(ACT_FREE, $urandom, last_freed);
      end else begin
        send(1'($urandom), $urandom, $urandom);
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    $display("Ran %0d requests: %0d allocations granted, %0d refused, %0d frees, %0d ignored",
             sb.checked, sb.alloc_ok, sb.alloc_fail, sb.frees_done, sb.frees_ignored);
    $display("Largest free order seen %0d, mismatches %0d, leftover %0d",
             sb.top_order, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
